[rtl/rpwu_pkg.sv]
// ============================================================================
// rpwu_pkg: shared types and constants for the Rprop weight update block
// Field widths, register indexes, sign codes, reset values and the Q4.12
// round-and-saturate helper.
// ============================================================================
`default_nettype none

package rpwu_pkg;

    localparam int NUM_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(NUM_ELEMENTS);
    localparam int STEP_W       = 31;
    localparam int FACT_W       = 16;
    localparam int DATA_W       = 32;
    localparam int SIGN_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;
    localparam int FRAC_SHIFT   = 12;

    // stored gradient sign codes
    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREASE_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECREASE_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REL_MAX_FACTOR  = 3'd5;

    // reset values
    localparam logic [STEP_W-1:0] RST_INITIAL_STEP    = 31'd65536;
    localparam logic [FACT_W-1:0] RST_INCREASE_FACTOR = 16'd4915;
    localparam logic [FACT_W-1:0] RST_DECREASE_FACTOR = 16'd1352;
    localparam logic [STEP_W-1:0] RST_MAX_STEP        = 31'd3276800;
    localparam logic [STEP_W-1:0] RST_MIN_STEP        = 31'd1;
    localparam logic [FACT_W-1:0] RST_REL_MAX_FACTOR  = 16'd0;

    localparam logic [FRAC_SHIFT:0] ROUND_HALF = 13'd2048;

    // one entry of the per-element state memory
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [SIGN_W-1:0] sign;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Q4.12 product -> Q16.16, round half up, saturate to 2^31-1
    function automatic logic [STEP_W-1:0] q12_round_sat(input logic [47:0] prod);
        logic [48:0] sum;
        logic [36:0] shifted;
        sum     = {1'b0, prod} + 49'(ROUND_HALF);
        shifted = sum[48:FRAC_SHIFT];
        if (|shifted[36:STEP_W]) begin
            return '1;
        end
        return shifted[STEP_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/rpwu_ram.sv]
// ============================================================================
// rpwu_ram: generic single-write, single-read RAM
// One write port, one read port with enable and registered read data.
// A read at the write address in the same cycle returns the old contents.
// ============================================================================
`default_nettype none

module rpwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/rprop_weight_update.sv]
// ============================================================================
// rprop_weight_update: Rprop- step and weight update, one element per item
// Keeps a step size and last gradient sign per element and produces the
// updated weight and step for every incoming gradient.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries restart, element index,
//   weight and gradient. Output channel (o_out_valid / i_out_stall) carries
//   the new weight and new step size, one result per input transfer.
//   Path: an input transfer passes the state RAM read (with the update stage
//   registers), then update logic into the result register, to o_out_valid.
//   Throughput: 1 item per cycle while the receiver does not stall, set by
//   the state RAM read-modify-write on its separate read and write ports;
//   back-to-back hits on one element are forwarded.
//   Reset (synchronous, active low): pipeline and output empty, every entry
//   invalid, configuration registers at their defaults. No clearing pass;
//   an invalid entry reads as initial_step with sign zero.
//   Receiver stall: the result register holds; the update stage holds behind
//   it and o_in_stall rises only when both are occupied.
//   Configuration writes (i_cfg_we) take effect at once; write only when idle.
// ============================================================================
`default_nettype none

module rprop_weight_update
    import rpwu_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic                         i_restart,
    input  wire logic [IDX_W-1:0]             i_element_index,
    input  wire logic signed [DATA_W-1:0]     i_weight,
    input  wire logic signed [DATA_W-1:0]     i_gradient,
    // output channel
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      logic signed [DATA_W-1:0]     o_new_weight,
    output      logic [STEP_W-1:0]            o_new_step_size
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] r_initial_step;
    logic [FACT_W-1:0] r_increase_factor;
    logic [FACT_W-1:0] r_decrease_factor;
    logic [STEP_W-1:0] r_max_step;
    logic [STEP_W-1:0] r_min_step;
    logic [FACT_W-1:0] r_rel_max_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_step    <= RST_INITIAL_STEP;
            r_increase_factor <= RST_INCREASE_FACTOR;
            r_decrease_factor <= RST_DECREASE_FACTOR;
            r_max_step        <= RST_MAX_STEP;
            r_min_step        <= RST_MIN_STEP;
            r_rel_max_factor  <= RST_REL_MAX_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INITIAL_STEP:    r_initial_step    <= i_cfg_data;
                REG_INCREASE_FACTOR: r_increase_factor <= i_cfg_data[FACT_W-1:0];
                REG_DECREASE_FACTOR: r_decrease_factor <= i_cfg_data[FACT_W-1:0];
                REG_MAX_STEP:        r_max_step        <= i_cfg_data;
                REG_MIN_STEP:        r_min_step        <= i_cfg_data;
                REG_REL_MAX_FACTOR:  r_rel_max_factor  <= i_cfg_data[FACT_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // update stage input registers (RAM read runs alongside)
    // ------------------------------------------------------------------
    logic              r_s1_restart;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [DATA_W-1:0] r_s1_weight;
    logic [DATA_W-1:0] r_s1_grad;

    // forwarding of the entry written in the same cycle as our RAM read
    logic   r_fw_hit;
    t_entry r_fw_entry;

    logic [NUM_ELEMENTS-1:0] r_entry_valid;
    logic [NUM_ELEMENTS-1:0] n_entry_valid;

    t_entry ram_rd;
    t_entry n_entry;

    rpwu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (n_entry),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_element_index),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_restart <= i_restart;
            r_s1_idx     <= i_element_index;
            r_s1_weight  <= unsigned'(i_weight);
            r_s1_grad    <= unsigned'(i_gradient);
            r_fw_entry   <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_fw_hit      <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fw_hit   <= s1_adv && (r_s1_idx == i_element_index);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fw_hit   <= 1'b0;
            end
            if (s1_adv) begin
                r_entry_valid <= n_entry_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // update logic
    // ------------------------------------------------------------------
    logic                entry_ok;
    t_entry              cur;
    logic [STEP_W-1:0]   cur_step;
    logic [SIGN_W-1:0]   cur_sign;
    logic [SIGN_W-1:0]   g_sign;
    logic                do_grow;
    logic                do_shrink;
    logic [FACT_W-1:0]   factor;
    logic [46:0]         step_prod;
    logic [STEP_W-1:0]   scaled;
    logic [DATA_W-1:0]   abs_w;
    logic [47:0]         rel_prod;
    logic [STEP_W-1:0]   limit;
    logic [STEP_W-1:0]   n_step;
    logic [DATA_W:0]     w_ext;
    logic [DATA_W:0]     w_sum;
    logic [DATA_W-1:0]   n_weight;

    always_comb begin
        // restart in this item invalidates everything, this entry included
        entry_ok = r_entry_valid[r_s1_idx] && !r_s1_restart;
        cur      = r_fw_hit ? r_fw_entry : ram_rd;
        cur_step = entry_ok ? cur.step : r_initial_step;
        cur_sign = entry_ok ? cur.sign : SIGN_ZERO;

        if (r_s1_grad == '0) begin
            g_sign = SIGN_ZERO;
        end else if (r_s1_grad[DATA_W-1]) begin
            g_sign = SIGN_NEG;
        end else begin
            g_sign = SIGN_POS;
        end

        do_grow   = (g_sign != SIGN_ZERO) && (g_sign == cur_sign);
        do_shrink = (g_sign != SIGN_ZERO) && (cur_sign != SIGN_ZERO) && !do_grow;

        // one shared multiplier for grow / shrink
        factor    = do_grow ? r_increase_factor : r_decrease_factor;
        step_prod = 47'(cur_step) * 47'(factor);
        scaled    = q12_round_sat({1'b0, step_prod});

        // relative growth limit; |-2^31| fits the unsigned 32-bit magnitude
        abs_w    = r_s1_weight[DATA_W-1] ? (~r_s1_weight + 32'd1) : r_s1_weight;
        rel_prod = 48'(abs_w) * 48'(r_rel_max_factor);
        limit    = (r_rel_max_factor != '0) ? q12_round_sat(rel_prod) : r_max_step;

        if (do_grow) begin
            n_step = (scaled < limit) ? scaled : limit;
        end else if (do_shrink) begin
            n_step = (scaled > r_min_step) ? scaled : r_min_step;
        end else begin
            n_step = cur_step;
        end

        n_entry.step = n_step;
        n_entry.sign = do_shrink ? SIGN_ZERO : g_sign;

        // weight moves against the gradient sign, saturated to 32 bits
        w_ext = {r_s1_weight[DATA_W-1], r_s1_weight};
        unique case (g_sign)
            SIGN_POS: w_sum = w_ext - {2'b00, n_step};
            SIGN_NEG: w_sum = w_ext + {2'b00, n_step};
            default:  w_sum = w_ext;
        endcase
        if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
            n_weight = w_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_weight = w_sum[DATA_W-1:0];
        end

        n_entry_valid           = r_s1_restart ? '0 : r_entry_valid;
        n_entry_valid[r_s1_idx] = 1'b1;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_out_weight;
    logic [STEP_W-1:0] r_out_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_weight <= n_weight;
            r_out_step   <= n_step;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_weight    = signed'(r_out_weight);
    assign o_new_step_size = r_out_step;

`ifndef SYNTHESIS
    // a forwarded entry only exists for an item sitting in the update stage
    a_fw_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fw_hit |-> r_s1_valid)
        else $error("forwarding flag set with empty update stage");

    // a restart leaves exactly the updated entry valid
    a_restart_one_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_restart) |=> $onehot(r_entry_valid))
        else $error("restart did not leave a single valid entry");

    // every item leaving the update stage lands in the result register
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("update result lost");

    // input side stalls only while the update stage is blocked
    a_stall_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked pipeline");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_rprop_weight_update.sv]
// ============================================================================
// tb_rprop_weight_update: self-checking testbench for the Rprop update block
// Drives gradient transfers through several register settings, predicts the
// new weight and step per element and checks every result transfer in order.
// ============================================================================
`timescale 1ns / 100ps

module tb_rprop_weight_update
    import rpwu_pkg::*;
();

    // register indexes past the last real register; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int NUM_PHASES       = 7;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int LONG_HOLD_CYCLES = 48;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct {
        logic signed [DATA_W-1:0] new_weight;
        logic [STEP_W-1:0]        new_step_size;
    } t_update;

    typedef struct {
        logic [STEP_W-1:0] initial_step;
        logic [FACT_W-1:0] increase_factor;
        logic [FACT_W-1:0] decrease_factor;
        logic [STEP_W-1:0] max_step;
        logic [STEP_W-1:0] min_step;
        logic [FACT_W-1:0] rel_max_factor;
    } t_cfg;

    // ------------------------------------------------------------------------
    // Update tracker: mirrors the per-element step/sign memory, computes the
    // expected result of every accepted transfer and checks results in order.
    // ------------------------------------------------------------------------
    class rprop_update_tracker;
        logic [STEP_W-1:0] initial_step;
        logic [FACT_W-1:0] increase_factor;
        logic [FACT_W-1:0] decrease_factor;
        logic [STEP_W-1:0] max_step;
        logic [STEP_W-1:0] min_step;
        logic [FACT_W-1:0] rel_max_factor;
        logic [STEP_W-1:0] step_mem   [NUM_ELEMENTS];
        logic [SIGN_W-1:0] sign_mem   [NUM_ELEMENTS];
        bit                entry_live [NUM_ELEMENTS];
        t_update           pending_updates [$];
        int                errors;

        function new();
            initial_step    = RST_INITIAL_STEP;
            increase_factor = RST_INCREASE_FACTOR;
            decrease_factor = RST_DECREASE_FACTOR;
            max_step        = RST_MAX_STEP;
            min_step        = RST_MIN_STEP;
            rel_max_factor  = RST_REL_MAX_FACTOR;
            foreach (entry_live[k]) entry_live[k] = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INITIAL_STEP:    initial_step    = data[STEP_W-1:0];
                REG_INCREASE_FACTOR: increase_factor = data[FACT_W-1:0];
                REG_DECREASE_FACTOR: decrease_factor = data[FACT_W-1:0];
                REG_MAX_STEP:        max_step        = data[STEP_W-1:0];
                REG_MIN_STEP:        min_step        = data[STEP_W-1:0];
                REG_REL_MAX_FACTOR:  rel_max_factor  = data[FACT_W-1:0];
                default: ;
            endcase
        endfunction

        // a * f with f in Q4.12, rounded half up, clipped to 2^31-1
        function logic [STEP_W-1:0] scale_q12(input logic [31:0] a,
                                              input logic [FACT_W-1:0] f);
            logic [47:0] prod;
            logic [48:0] sum;
            logic [48:0] shifted;
            prod    = {16'd0, a} * {32'd0, f};
            sum     = {1'b0, prod} + 49'd2048;
            shifted = sum >> FRAC_SHIFT;
            if (shifted > 49'h7FFF_FFFF) return '1;
            return shifted[STEP_W-1:0];
        endfunction

        function void predict_update(input logic                     restart,
                                     input logic [IDX_W-1:0]         elem,
                                     input logic signed [DATA_W-1:0] w,
                                     input logic signed [DATA_W-1:0] g);
            logic [STEP_W-1:0] step;
            logic [STEP_W-1:0] grown;
            logic [STEP_W-1:0] limit;
            logic [STEP_W-1:0] shrunk;
            logic [SIGN_W-1:0] last;
            logic [SIGN_W-1:0] cur;
            logic [31:0]       abs_w;
            longint            next_w;
            t_update           upd;

            if (restart) begin
                foreach (entry_live[k]) entry_live[k] = 1'b0;
            end
            cur = (g > 0) ? SIGN_POS : ((g < 0) ? SIGN_NEG : SIGN_ZERO);
            if (entry_live[elem]) begin
                step = step_mem[elem];
                last = sign_mem[elem];
            end else begin
                step = initial_step;
                last = SIGN_ZERO;
            end

            if (cur != SIGN_ZERO && cur == last) begin
                // same direction again: grow, bounded by max or |factor * w|
                grown = scale_q12({1'b0, step}, increase_factor);
                limit = max_step;
                if (rel_max_factor != '0) begin
                    abs_w = (w < 0) ? -w : w;
                    limit = scale_q12(abs_w, rel_max_factor);
                end
                step = (grown < limit) ? grown : limit;
            end else if (cur != SIGN_ZERO && last != SIGN_ZERO) begin
                // direction flipped: shrink, not below min_step, and forget the sign
                shrunk = scale_q12({1'b0, step}, decrease_factor);
                step   = (shrunk > min_step) ? shrunk : min_step;
                cur    = SIGN_ZERO;
            end

            next_w = longint'(w);
            if (g > 0) next_w = next_w - longint'({1'b0, step});
            else if (g < 0) next_w = next_w + longint'({1'b0, step});
            if (next_w > 64'sd2147483647) next_w = 64'sd2147483647;
            if (next_w < -64'sd2147483648) next_w = -64'sd2147483648;

            step_mem[elem]   = step;
            sign_mem[elem]   = cur;
            entry_live[elem] = 1'b1;

            upd.new_weight    = next_w[DATA_W-1:0];
            upd.new_step_size = step;
            pending_updates.push_back(upd);
        endfunction

        function void check_update(input logic signed [DATA_W-1:0] nw,
                                   input logic [STEP_W-1:0]        ns);
            t_update upd;
            if (pending_updates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: new_weight %0d new_step_size %0d",
                         $time, nw, ns);
                return;
            end
            upd = pending_updates.pop_front();
            if (nw !== upd.new_weight) begin
                errors++;
                $display("%0t: new_weight mismatch: expected %0d, actual %0d",
                         $time, upd.new_weight, nw);
            end
            if (ns !== upd.new_step_size) begin
                errors++;
                $display("%0t: new_step_size mismatch: expected %0d, actual %0d",
                         $time, upd.new_step_size, ns);
            end
        endfunction

        function int pending();
            return pending_updates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input is at a known value from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data      = '0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic                     i_restart       = 1'b0;
    logic [IDX_W-1:0]         i_element_index = '0;
    logic signed [DATA_W-1:0] i_weight        = '0;
    logic signed [DATA_W-1:0] i_gradient      = '0;
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic signed [DATA_W-1:0] o_new_weight;
    logic [STEP_W-1:0]        o_new_step_size;

    rprop_update_tracker updates;

    // idle rates in percent per cycle, changed per phase
    int send_idle_pct = 18;
    int recv_idle_pct = 55;
    // long receiver hold-off: requested by the stimulus, counted by the receiver
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;

    rprop_weight_update u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .i_element_index (i_element_index),
        .i_weight        (i_weight),
        .i_gradient      (i_gradient),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_new_weight    (o_new_weight),
        .o_new_step_size (o_new_step_size)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stall per cycle, or a long hold-off on request so the
    // pipeline fills and pushes back on the input side.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result monitor: every output transfer is checked against the oldest
    // pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            updates.check_update(o_new_weight, o_new_step_size);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. All of them are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // One input transfer; valid stays high on return so back-to-back items
    // need no extra assignment in the same step.
    task automatic send_update(input logic                     restart,
                               input logic [IDX_W-1:0]         elem,
                               input logic signed [DATA_W-1:0] w,
                               input logic signed [DATA_W-1:0] g);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_restart       <= restart;
        i_element_index <= elem;
        i_weight        <= w;
        i_gradient      <= g;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        updates.predict_update(restart, elem, w, g);
        @(negedge i_clk);
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (updates.pending() != 0) @(negedge i_clk);
    endtask

    // Writes every register, plus the two unused indexes with junk.
    task automatic load_config(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx_list [8];
        logic [CFG_DATA_W-1:0] val_list [8];
        idx_list = '{REG_INITIAL_STEP, REG_INCREASE_FACTOR, REG_DECREASE_FACTOR,
                     REG_MAX_STEP, REG_MIN_STEP, REG_REL_MAX_FACTOR,
                     REG_SPARE_LO, REG_SPARE_HI};
        val_list = '{c.initial_step, CFG_DATA_W'(c.increase_factor),
                     CFG_DATA_W'(c.decrease_factor), c.max_step, c.min_step,
                     CFG_DATA_W'(c.rel_max_factor),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            updates.write_reg(idx_list[k], val_list[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg phase_setting(input int ph);
        t_cfg c;
        c = '{RST_INITIAL_STEP, RST_INCREASE_FACTOR, RST_DECREASE_FACTOR,
              RST_MAX_STEP, RST_MIN_STEP, RST_REL_MAX_FACTOR};
        case (ph)
            // everything at the top: products and weights saturate
            1: c = '{31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF, 16'd0};
            // everything at the bottom: steps collapse to zero
            2: c = '{31'd1, 16'd0, 16'd0, 31'd0, 31'd0, 16'd0};
            // relative limit of 1.0, doubling growth, halving shrink
            3: c = '{31'd65536, 16'd8192, 16'd2048, 31'h7FFF_FFFF, 31'd16, 16'd4096};
            // widest relative factor
            4: c = '{31'd1 << 20, 16'd4915, 16'd1352, 31'd1 << 24, 31'd1 << 10,
                     16'hFFFF};
            5: begin
                c.initial_step    = STEP_W'($urandom_range(32'h7FFF_FFFF, 1));
                c.increase_factor = FACT_W'($urandom);
                c.decrease_factor = FACT_W'($urandom);
                c.max_step        = STEP_W'($urandom);
                c.min_step        = STEP_W'($urandom) >> $urandom_range(30);
                c.rel_max_factor  = $urandom_range(1) ? FACT_W'($urandom) : '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_weight();
        int unsigned              r;
        logic signed [DATA_W-1:0] w;
        r = $urandom_range(99);
        if (r < 40) begin
            w = $urandom;
        end else if (r < 65) begin
            w = $urandom_range(1 << 21);
            if ($urandom_range(1)) w = -w;
        end else if (r < 75) begin
            w = '0;
        end else if (r < 85) begin
            case ($urandom_range(3))
                0: w = 32'sh7FFF_FFFF;
                1: w = 32'sh8000_0000;
                2: w = 32'sh7FFF_0000;
                default: w = 32'sh8000_FFFF;
            endcase
        end else begin
            w = $signed($urandom) >>> $urandom_range(20, 1);
        end
        return w;
    endfunction

    // gradient with the requested direction (0 gives a zero gradient)
    function automatic logic signed [DATA_W-1:0] pick_gradient(input int dir);
        logic signed [DATA_W-1:0] mag;
        if (dir == 0) return '0;
        mag = $urandom >> $urandom_range(31, 1);
        if (mag == 0) mag = 1;
        return (dir > 0) ? mag : -mag;
    endfunction

    // Hand-picked cases under the reset settings: growth, zero gradient,
    // sign flip and shrink, weight saturation both ways, restart.
    task automatic run_directed_defaults();
        send_update(1'b1, 6'd0,  32'sd0,           32'sd1);
        send_update(1'b0, 6'd0,  32'sd0,           32'sh0001_0000);
        send_update(1'b0, 6'd0,  32'sh0010_0000,   32'sh7FFF_FFFF);
        send_update(1'b0, 6'd0,  32'sh0010_0000,   32'sd0);
        send_update(1'b0, 6'd0,  32'sh0010_0000,   32'sd5);
        send_update(1'b0, 6'd0,  32'sh0010_0000,   -32'sd1);
        send_update(1'b0, 6'd0,  -32'sh0003_0000,  32'sh8000_0000);
        send_update(1'b0, 6'd0,  -32'sh0003_0000,  -32'sd7);
        send_update(1'b0, 6'd63, 32'sh7FFF_FFFF,   -32'sd3);
        send_update(1'b0, 6'd63, 32'sh8000_0000,   32'sd2);
        send_update(1'b0, 6'd1,  32'sh7FFF_FFFF,   32'sh7FFF_FFFF);
        send_update(1'b0, 6'd1,  32'sh8000_0000,   32'sh8000_0000);
        send_update(1'b1, 6'd63, 32'sd0,           -32'sd1);
        send_update(1'b0, 6'd0,  -32'sd1,          32'sd1);
        send_update(1'b0, 6'd42, -32'sd5,          32'sd0);
        send_update(1'b0, 6'd21, 32'sd5,           32'sd9);
    endtask

    // Relative limit active: a zero weight pins the grown step to zero,
    // the most negative weight saturates the limit.
    task automatic run_directed_relative();
        send_update(1'b0, 6'd2, 32'sd0,          32'sd3);
        send_update(1'b0, 6'd2, 32'sd0,          32'sd3);
        send_update(1'b0, 6'd3, -32'sh0000_8000, -32'sd1);
        send_update(1'b0, 6'd3, -32'sh0000_8000, -32'sd1);
        send_update(1'b0, 6'd3, 32'sh8000_0000,  -32'sd4);
    endtask

    // Mostly runs of gradients on one element with a steady direction and
    // occasional flips or zeros; the rest is unrelated noise.
    task automatic run_random(input int n_items);
        int               sent;
        int               run_len;
        int               dir;
        int unsigned      roll;
        bit               held;
        bit               paused;
        logic [IDX_W-1:0] elem;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!held && sent >= n_items / 3) begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && sent >= (2 * n_items) / 3) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(99) < 15) begin
                send_update($urandom_range(99) < 3, IDX_W'($urandom),
                            $urandom, $urandom);
                sent++;
            end else begin
                elem    = ($urandom_range(99) < 70) ? IDX_W'($urandom_range(7))
                                                    : IDX_W'($urandom);
                run_len = $urandom_range(24, 1);
                dir     = $urandom_range(1) ? 1 : -1;
                for (int k = 0; k < run_len && sent < n_items; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 6) dir = -dir;
                    send_update($urandom_range(79) == 0, elem, pick_weight(),
                                pick_gradient((roll >= 6 && roll < 10) ? 0 : dir));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        updates = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // sender idles lightly first, then the receiver, then neither
            if (ph < 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 55;
            end else if (ph < 5) begin
                send_idle_pct = 55;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // phase 0 runs on the reset values; later phases reprogram
            if (ph != 0) begin
                wait_drained();
                load_config(phase_setting(ph));
            end
            if (ph == 0) run_directed_defaults();
            if (ph == 3) run_directed_relative();
            run_random(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (updates.errors == 0 && updates.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
